// ===== rtl/sync_len_xor_frame_parser_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SYNC_LEN_XOR_FRAME_PARSER_DEFINES_SVH
`define SYNC_LEN_XOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define SLXFP_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define SLXFP_IMPLIES_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser check failed");

`endif

// ===== rtl/slxfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame parser package
// Types and constants shared by the frame parser files.
// ----------------------------------------------------------------------------
package slxfp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [8:0] MIN_REPORT  = 9'd7;
	localparam logic [8:0] COUNT_MAX   = 9'd511;
	localparam logic [8:0] POS_SYNC1   = 9'd1;
	localparam logic [8:0] POS_SYNC2   = 9'd2;
	localparam logic [8:0] POS_CMD     = 9'd3;
	localparam logic [8:0] POS_LEN     = 9'd4;
	localparam logic [8:0] POS_DATA    = 9'd5;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_BAD_SYNC  = 3'd2,
		ST_SHORT_LEN = 3'd3,
		ST_BAD_SUM   = 3'd4
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic       valid_res;
		status_t    status;
		logic [7:0] cmd_byte;
		logic [7:0] payload_len;
		logic [7:0] checksum_rx;
	} result_t;

endpackage

// ===== rtl/slxfp_if.sv =====
// ----------------------------------------------------------------------------
// Frame parser channels
// Valid/ready channels for incoming bytes and outgoing results.
// ----------------------------------------------------------------------------
interface slxfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       last;

	modport source (output valid, output byte_in, output last, input ready);
	modport sink (input valid, input byte_in, input last, output ready);
endinterface

interface slxfp_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [7:0] data_index;
	logic       valid_res;
	logic [2:0] status;
	logic [7:0] cmd_byte;
	logic [7:0] payload_len;
	logic [7:0] checksum_rx;

	modport source (output valid, output kind, output data_byte, output data_index,
		output valid_res, output status, output cmd_byte, output payload_len,
		output checksum_rx, input ready);
	modport sink (input valid, input kind, input data_byte, input data_index,
		input valid_res, input status, input cmd_byte, input payload_len,
		input checksum_rx, output ready);
endinterface

// ===== rtl/sync_len_xor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Sync word / length / XOR checksum frame parser
// Splits a byte stream into reports, emits each data byte and a verdict
// on the last byte of every report.
// ----------------------------------------------------------------------------
// Channel   Role   Payload
// bytes     sink   byte_in, last
// results   source kind, data_byte, data_index, valid_res, status,
//                  cmd_byte, payload_len, checksum_rx
//
// One byte is taken per cycle unless results stalls; each byte is held
// in the input register, its result then in the result register. The rate
// is set by the single frame-state update between those two registers.
// Reset clears the frame state and both valid flags.
// A stalled result holds the result register; the input register then
// holds too, and bytes stops taking new transfers.
// ----------------------------------------------------------------------------
`include "sync_len_xor_frame_parser_defines.svh"

module sync_len_xor_frame_parser
	import slxfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	slxfp_byte_if.sink            bytes,
	slxfp_result_if.source        results
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [8:0] count_q;
	logic       sync_ok_q;
	logic [7:0] cmd_q;
	logic [7:0] len_q;
	logic [7:0] xor_q;
	logic [7:0] sum_q;

	logic       out_valid_q;
	result_t    out_q;

	logic       adv;
	logic [8:0] data_end;
	logic       is_data;
	logic [8:0] count_n;
	logic       sync_ok_n;
	logic [7:0] cmd_n;
	logic [7:0] len_n;
	logic [7:0] xor_n;
	logic [7:0] sum_n;
	logic [9:0] need_size;
	result_t    res;
	logic       frame_end;
	logic       verdict_out;

	assign adv = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.byte_in;
			last_s1 <= bytes.last;
		end
	end

	always_comb begin
		data_end  = POS_DATA + {1'b0, len_q};
		is_data   = 1'b0;
		sync_ok_n = sync_ok_q;
		cmd_n     = cmd_q;
		len_n     = len_q;
		xor_n     = xor_q;
		sum_n     = sum_q;
		if (count_q == POS_SYNC1) begin
			if (byte_s1 != SYNC_FIRST) begin
				sync_ok_n = 1'b0;
			end
		end else if (count_q == POS_SYNC2) begin
			if (byte_s1 != SYNC_SECOND) begin
				sync_ok_n = 1'b0;
			end
		end else if (count_q == POS_CMD) begin
			cmd_n = byte_s1;
			xor_n = xor_q ^ byte_s1;
		end else if (count_q == POS_LEN) begin
			len_n = byte_s1;
			xor_n = xor_q ^ byte_s1;
		end else if (count_q >= POS_DATA && count_q < data_end) begin
			xor_n   = xor_q ^ byte_s1;
			is_data = 1'b1;
		end else if (count_q >= POS_DATA && count_q == data_end) begin
			sum_n = byte_s1;
		end
		count_n   = (count_q < COUNT_MAX) ? count_q + 9'd1 : count_q;
		need_size = 10'd6 + {2'b00, len_n};

		res = '0;
		if (last_s1) begin
			res.kind = KIND_VERDICT;
			if (count_n < MIN_REPORT) begin
				res.status = ST_SHORT;
			end else if (!sync_ok_n) begin
				res.status = ST_BAD_SYNC;
			end else if ({1'b0, count_n} < need_size) begin
				res.status      = ST_SHORT_LEN;
				res.payload_len = len_n;
			end else if (xor_n != sum_n) begin
				res.status      = ST_BAD_SUM;
				res.payload_len = len_n;
				res.checksum_rx = sum_n;
			end else begin
				res.status      = ST_OK;
				res.valid_res   = 1'b1;
				res.cmd_byte    = cmd_n;
				res.payload_len = len_n;
				res.checksum_rx = sum_n;
			end
		end else begin
			res.kind       = KIND_DATA;
			res.data_byte  = byte_s1;
			res.data_index = 8'(count_q - POS_DATA);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sync_ok_q <= 1'b1;
			cmd_q     <= '0;
			len_q     <= '0;
			xor_q     <= '0;
			sum_q     <= '0;
		end else if (adv) begin
			if (last_s1) begin
				count_q   <= '0;
				sync_ok_q <= 1'b1;
				cmd_q     <= '0;
				len_q     <= '0;
				xor_q     <= '0;
				sum_q     <= '0;
			end else begin
				count_q   <= count_n;
				sync_ok_q <= sync_ok_n;
				cmd_q     <= cmd_n;
				len_q     <= len_n;
				xor_q     <= xor_n;
				sum_q     <= sum_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && (last_s1 || is_data)) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (last_s1 || is_data)) begin
			out_q <= res;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.kind        = out_q.kind;
	assign results.data_byte   = out_q.data_byte;
	assign results.data_index  = out_q.data_index;
	assign results.valid_res   = out_q.valid_res;
	assign results.status      = out_q.status;
	assign results.cmd_byte    = out_q.cmd_byte;
	assign results.payload_len = out_q.payload_len;
	assign results.checksum_rx = out_q.checksum_rx;

	assign frame_end   = adv && last_s1;
	assign verdict_out = out_valid_q && out_q.kind == KIND_VERDICT;

	`SLXFP_IMPLIES(a_verdict_flag, verdict_out, out_q.valid_res == (out_q.status == ST_OK))
	`SLXFP_IMPLIES_NEXT(a_frame_cleared, frame_end, count_q == '0 && sync_ok_q && xor_q == '0)
	`SLXFP_IMPLIES_NEXT(a_count_saturates, count_q == COUNT_MAX && !frame_end, count_q == COUNT_MAX)

endmodule

// ===== bench/slxfp_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser scoreboard
// Watches both channels of the frame parser. Every accepted byte runs
// through a local copy of the frame state, which queues the data result or
// verdict that the byte should cause. Every accepted result is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module slxfp_scoreboard
	import slxfp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	slxfp_byte_if   bytes,
	slxfp_result_if results,
	output int      errors,
	output int      waiting
);

	logic [8:0] rx_count;
	logic       rx_sync_ok;
	logic [7:0] rx_cmd;
	logic [7:0] rx_len;
	logic [7:0] rx_xor;
	logic [7:0] rx_sum;
	result_t    due_results [$];
	int         fails = 0;
	int         pending = 0;

	assign errors = fails;
	assign waiting = pending;

	task automatic clear_frame();
		rx_count = '0;
		rx_sync_ok = 1'b1;
		rx_cmd = '0;
		rx_len = '0;
		rx_xor = '0;
		rx_sum = '0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		result_t    r;
		logic [8:0] pos;
		logic [9:0] data_end;
		logic       is_data;
		pos = rx_count;
		data_end = 10'(POS_DATA) + 10'(rx_len);
		is_data = 1'b0;
		r = '0;
		if (pos == POS_SYNC1) begin
			if (b != SYNC_FIRST)
				rx_sync_ok = 1'b0;
		end else if (pos == POS_SYNC2) begin
			if (b != SYNC_SECOND)
				rx_sync_ok = 1'b0;
		end else if (pos == POS_CMD) begin
			rx_cmd = b;
			rx_xor = rx_xor ^ b;
		end else if (pos == POS_LEN) begin
			rx_len = b;
			rx_xor = rx_xor ^ b;
		end else if (pos >= POS_DATA && 10'(pos) < data_end) begin
			rx_xor = rx_xor ^ b;
			is_data = 1'b1;
		end else if (pos >= POS_DATA && 10'(pos) == data_end) begin
			rx_sum = b;
		end
		if (rx_count != COUNT_MAX)
			rx_count = rx_count + 9'd1;

		if (fin) begin
			r.kind = KIND_VERDICT;
			if (rx_count < MIN_REPORT) begin
				r.status = ST_SHORT;
			end else if (!rx_sync_ok) begin
				r.status = ST_BAD_SYNC;
			end else if (10'(rx_count) < 10'd6 + 10'(rx_len)) begin
				r.status = ST_SHORT_LEN;
				r.payload_len = rx_len;
			end else if (rx_xor != rx_sum) begin
				r.status = ST_BAD_SUM;
				r.payload_len = rx_len;
				r.checksum_rx = rx_sum;
			end else begin
				r.status = ST_OK;
				r.valid_res = 1'b1;
				r.cmd_byte = rx_cmd;
				r.payload_len = rx_len;
				r.checksum_rx = rx_sum;
			end
			due_results.push_back(r);
			clear_frame();
		end else if (is_data) begin
			r.kind = KIND_DATA;
			r.data_byte = b;
			r.data_index = 8'(pos - POS_DATA);
			due_results.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_frame();
			due_results.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got kind %0h data %0h status %0h",
						$time, results.kind, results.data_byte, results.status);
					fails++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", 8'(want.kind), 8'(results.kind));
					check_field("data_byte", want.data_byte, results.data_byte);
					check_field("data_index", want.data_index, results.data_index);
					check_field("valid_res", 8'(want.valid_res), 8'(results.valid_res));
					check_field("status", 8'(want.status), 8'(results.status));
					check_field("cmd_byte", want.cmd_byte, results.cmd_byte);
					check_field("payload_len", want.payload_len, results.payload_len);
					check_field("checksum_rx", want.checksum_rx, results.checksum_rx);
				end
			end
			if (bytes.valid && bytes.ready)
				parse_byte(bytes.byte_in, bytes.last);
		end
		pending = due_results.size();
	end

endmodule

// ===== bench/sync_len_xor_frame_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame parser testbench
// Feeds the frame parser a few hand-built reports, one report long enough
// to saturate the byte counter, and then random reports: mostly well-formed
// frames with random content, the rest with bad checksums, bad sync words,
// truncation or plain noise. Both sides idle at random. The scoreboard
// checks every result and reports its failure count for the verdict.
// ----------------------------------------------------------------------------
module sync_len_xor_frame_parser_tb;
	import slxfp_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   waiting;
	bit   idle_off;

	slxfp_byte_if   bytes();
	slxfp_result_if results();

	sync_len_xor_frame_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.results(results)
	);

	slxfp_scoreboard scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes),
		.results(results),
		.errors(errors),
		.waiting(waiting)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("sync_len_xor_frame_parser test failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			bytes.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes.valid <= 1'b1;
		bytes.byte_in <= b;
		bytes.last <= fin;
		do @(posedge clk); while (!bytes.ready);
		@(negedge clk);
	endtask

	task automatic send_report(input logic [7:0] rep [$]);
		foreach (rep[i])
			send_byte(rep[i], i == rep.size() - 1);
	endtask

	function automatic void make_frame(output logic [7:0] rep [$], input logic [7:0] len,
		input int pad, output int body);
		logic [7:0] sum;
		logic [7:0] cmd;
		logic [7:0] d;
		rep.delete();
		cmd = 8'($urandom);
		rep.push_back(8'($urandom));
		rep.push_back(SYNC_FIRST);
		rep.push_back(SYNC_SECOND);
		rep.push_back(cmd);
		rep.push_back(len);
		sum = cmd ^ len;
		repeat (len) begin
			d = 8'($urandom);
			sum = sum ^ d;
			rep.push_back(d);
		end
		rep.push_back(sum);
		repeat (pad) rep.push_back(8'($urandom));
		body = rep.size();
	endfunction

	initial begin
		int gap;
		results.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_off ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				results.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
			@(negedge clk);
		end
	end

	initial begin
		logic [7:0] rep [$];
		logic [7:0] len;
		int         body;
		int         useful;
		int         shape;
		int         cut;
		useful = 0;
		idle_off = 1'b0;
		arst_n <= 1'b0;
		bytes.valid <= 1'b0;
		bytes.byte_in <= 8'h00;
		bytes.last <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A report of a single byte is too short.
		rep = '{8'hFF};
		send_report(rep);
		// Minimal valid frame with one data byte.
		rep = '{8'h00, SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'h01, 8'h00, 8'hFE};
		send_report(rep);
		// Bad sync word; the data byte still comes out.
		rep = '{8'h01, SYNC_SECOND, SYNC_FIRST, 8'hFF, 8'h01, 8'h5A, 8'hA4};
		send_report(rep);
		// The report ends on a data byte.
		rep = '{8'h02, SYNC_FIRST, SYNC_SECOND, 8'h3C, 8'h03, 8'hA5, 8'h5A};
		send_report(rep);
		// Checksum mismatch with one byte of padding.
		rep = '{8'h03, SYNC_FIRST, SYNC_SECOND, 8'h81, 8'h00, 8'h00, 8'h00};
		send_report(rep);
		useful = 29;

		// Longest data field, padded past the point where the counter saturates.
		make_frame(rep, 8'd255, 251, body);
		send_report(rep);
		useful += body;

		while (useful < 650) begin
			if ($urandom_range(0, 7) == 0)
				idle_off = !idle_off;
			shape = $urandom_range(0, 99);
			len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(11, 60))
				: 8'($urandom_range(0, 10));
			make_frame(rep, len, $urandom_range(0, 3), body);
			if (shape >= 60 && shape < 70) begin
				rep[5 + len] = rep[5 + len] ^ 8'($urandom_range(1, 255));
			end else if (shape >= 70 && shape < 78) begin
				case ($urandom_range(0, 2))
					0: rep[1] = rep[1] ^ 8'($urandom_range(1, 255));
					1: rep[2] = rep[2] ^ 8'($urandom_range(1, 255));
					default: begin
						rep[1] = rep[1] ^ 8'($urandom_range(1, 255));
						rep[2] = rep[2] ^ 8'($urandom_range(1, 255));
					end
				endcase
			end else if (shape >= 78 && shape < 88) begin
				cut = $urandom_range(1, 5 + len);
				while (rep.size() > cut)
					void'(rep.pop_back());
				body = cut;
			end else if (shape >= 88) begin
				rep.delete();
				body = $urandom_range(1, 14);
				repeat (body) rep.push_back(8'($urandom));
				if (body > 2 && $urandom_range(0, 1) == 1) begin
					rep[1] = SYNC_FIRST;
					rep[2] = SYNC_SECOND;
				end
			end
			send_report(rep);
			useful += body;
		end

		bytes.valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && waiting == 0)
			$display("sync_len_xor_frame_parser test passed");
		else
			$display("sync_len_xor_frame_parser test failed");
		$finish;
	end

endmodule
